// ----- rtl/core/u8dec_pkg.sv -----
// package for the utf-8 to utf-32 decoder core
// widths, decode constants and the control/status structs; no dependencies
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 2;
    localparam int LEN_W  = 3;
    localparam int NUM_W  = 3;

    // escape code point base, the error byte is or-ed into the low byte
    localparam logic [CP_W-1:0]   ESC_BASE   = 21'h00DC00;

    localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;
    localparam logic [BYTE_W-1:0] MIN_AFT_E0 = 8'hA0;
    localparam logic [BYTE_W-1:0] MAX_AFT_ED = 8'h9F;
    localparam logic [BYTE_W-1:0] MIN_AFT_F0 = 8'h90;
    localparam logic [BYTE_W-1:0] MAX_AFT_F4 = 8'h8F;
    localparam logic [BYTE_W-1:0] TRAIL_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] TRAIL_TAG  = 8'h80;

    // sequence lengths by lead byte class
    localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

    // one decoded result before the run/string flags are added
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            esc;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic take;   // item accepted, load first result and the list
        logic next;   // move the next listed result to the output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can be loaded this cycle
        logic multi;     // item on the input decodes to more than one result
        logic last;      // listed result at the index is the final one
    } t_status;

endpackage

// ----- rtl/core/u8dec_if.sv -----
// valid/ready channel interfaces for the decoder core
// depends on u8dec_pkg for the field widths
`timescale 1ns / 1ps

interface u8dec_in_if;
    logic                          valid;
    logic                          ready;
    logic [u8dec_pkg::BYTE_W-1:0]  byte_in;
    logic                          end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8dec_out_if;
    logic                          valid;
    logic                          ready;
    logic [u8dec_pkg::CP_W-1:0]    code_point;
    logic                          is_escape;
    logic                          run_last;
    logic                          string_last;

    modport source (output valid, output code_point, output is_escape,
                    output run_last, output string_last, input ready);
    modport sink   (input valid, input code_point, input is_escape,
                    input run_last, input string_last, output ready);
endinterface

// ----- rtl/core/u8dec_ctrl.sv -----
// controller state machine of the decoder core
// depends on u8dec_pkg for the command and status structs
`timescale 1ns / 1ps

module u8dec_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  u8dec_pkg::t_status i_status,
    output logic               o_in_ready,
    output u8dec_pkg::t_cmd    o_cmd
);
    import u8dec_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_status.multi) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.next = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/u8dec_dpath.sv -----
// datapath of the decoder core: held bytes, decode, result list, output register
// depends on u8dec_pkg for constants and structs
`timescale 1ns / 1ps

module u8dec_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [u8dec_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic                          i_end_of_string,
    input  u8dec_pkg::t_cmd               i_cmd,
    input  logic                          i_out_ready,
    output u8dec_pkg::t_status            o_status,
    output logic                          o_out_valid,
    output logic [u8dec_pkg::CP_W-1:0]    o_code_point,
    output logic                          o_is_escape,
    output logic                          o_run_last,
    output logic                          o_string_last
);
    import u8dec_pkg::*;

    function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if (b < 8'h80)                      len = LEN_1;
        else if (b >= 8'hC2 && b <= 8'hDF)  len = LEN_2;
        else if (b >= 8'hE0 && b <= 8'hEF)  len = LEN_3;
        else if (b >= 8'hF0 && b <= LEAD_F4) len = LEN_4;
        else                                len = LEN_BAD;
        return len;
    endfunction

    function automatic t_res esc_res(input logic [BYTE_W-1:0] b);
        t_res r;
        r.cp  = ESC_BASE | {{(CP_W-BYTE_W){1'b0}}, b};
        r.esc = 1'b1;
        return r;
    endfunction

    // held prefix of a pending sequence
    logic [BYTE_W-1:0] r_held [0:2];
    logic [CNT_W-1:0]  r_cnt;

    // results of the current item that still wait for the output register
    t_res              r_list [1:3];
    logic [NUM_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic              r_eos;

    logic              r_ov;
    logic [CP_W-1:0]   r_cp;
    logic              r_esc;
    logic              r_rl;
    logic              r_sl;

    // decode of the input byte against the held prefix
    logic [LEN_W-1:0]  lead_len;
    logic [LEN_W-1:0]  b_len;
    logic [LEN_W-1:0]  pos;
    logic              is_trail;
    logic              bad_second;
    logic              ok;
    logic              complete;
    logic              extend;
    logic              fresh;
    logic [CNT_W-1:0]  k;
    t_res              tail;
    logic              tail_v;
    logic [CP_W-1:0]   asm_cp;
    t_res              dec_list [0:3];
    logic [NUM_W-1:0]  dec_n;
    logic              out_free;

    assign lead_len   = seq_len(r_held[0]);
    assign b_len      = seq_len(i_byte_in);
    assign pos        = {1'b0, r_cnt};
    assign is_trail   = (i_byte_in & TRAIL_MASK) == TRAIL_TAG;
    assign bad_second = (r_held[0] == LEAD_E0 && i_byte_in < MIN_AFT_E0) ||
                        (r_held[0] == LEAD_ED && i_byte_in > MAX_AFT_ED) ||
                        (r_held[0] == LEAD_F0 && i_byte_in < MIN_AFT_F0) ||
                        (r_held[0] == LEAD_F4 && i_byte_in > MAX_AFT_F4);
    assign ok         = (r_cnt != '0) && (lead_len >= LEN_2) && (pos < lead_len) &&
                        is_trail && !((pos == 3'd1) && bad_second);
    assign complete   = ok && ((pos + 3'd1) == lead_len);
    assign extend     = ok && !complete;
    assign fresh      = !ok;

    // code point assembly by sequence length
    always_comb begin
        unique case (lead_len)
            LEN_2:   asm_cp = {10'd0, r_held[0][4:0], i_byte_in[5:0]};
            LEN_3:   asm_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], i_byte_in[5:0]};
            default: asm_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0],
                               i_byte_in[5:0]};
        endcase
    end

    // escapes of held bytes come first, then at most one tail result
    always_comb begin
        tail   = esc_res(i_byte_in);
        tail_v = 1'b0;
        k      = '0;
        if (complete) begin
            tail.cp  = asm_cp;
            tail.esc = 1'b0;
            tail_v   = 1'b1;
        end else if (extend) begin
            tail_v = i_end_of_string;
            k      = i_end_of_string ? r_cnt : '0;
        end else begin
            k = r_cnt;
            if (b_len == LEN_1) begin
                tail.cp  = {{(CP_W-BYTE_W){1'b0}}, i_byte_in};
                tail.esc = 1'b0;
                tail_v   = 1'b1;
            end else if (b_len == LEN_BAD) begin
                tail_v = 1'b1;
            end else begin
                tail_v = i_end_of_string;
            end
        end
        dec_list[0] = (k > 2'd0) ? esc_res(r_held[0]) : tail;
        dec_list[1] = (k > 2'd1) ? esc_res(r_held[1]) : tail;
        dec_list[2] = (k > 2'd2) ? esc_res(r_held[2]) : tail;
        dec_list[3] = tail;
        dec_n       = {1'b0, k} + {2'b00, tail_v};
    end

    assign out_free          = !r_ov || i_out_ready;
    assign o_status.out_free = out_free;
    assign o_status.multi    = dec_n > 3'd1;
    assign o_status.last     = {1'b0, r_idx} == (r_n - 3'd1);

    // held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.take) begin
            if (extend && !i_end_of_string) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (fresh && b_len >= LEN_2 && !i_end_of_string) begin
                r_cnt <= 2'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (extend) begin
                r_held[r_cnt] <= i_byte_in;
            end else if (fresh) begin
                r_held[0] <= i_byte_in;
            end
        end
    end

    // result list
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_list[1] <= dec_list[1];
            r_list[2] <= dec_list[2];
            r_list[3] <= dec_list[3];
            r_n       <= dec_n;
            r_eos     <= i_end_of_string;
            r_idx     <= 2'd1;
        end else if (i_cmd.next) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((i_cmd.take && dec_n != '0) || i_cmd.next) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cp  <= dec_list[0].cp;
            r_esc <= dec_list[0].esc;
            r_rl  <= dec_n == 3'd1;
            r_sl  <= i_end_of_string && (dec_n == 3'd1);
        end else if (i_cmd.next) begin
            r_cp  <= r_list[r_idx].cp;
            r_esc <= r_list[r_idx].esc;
            r_rl  <= o_status.last;
            r_sl  <= r_eos && o_status.last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_code_point  = r_cp;
    assign o_is_escape   = r_esc;
    assign o_run_last    = r_rl;
    assign o_string_last = r_sl;

endmodule

// ----- rtl/core/utf8_to_utf32_decoder_core.sv -----
// top level of the utf-8 to utf-32 decoder core
// depends on u8dec_pkg, u8dec_if, u8dec_ctrl and u8dec_dpath
`timescale 1ns / 1ps

// usage
// - i_in carries one utf-8 byte per item plus an end-of-string mark
// - o_out carries decoded code points; undecodable bytes come out as
//   0xdc80-0xdcff with is_escape set, run_last marks the final result of an
//   input byte and string_last the final result of the string
// - a byte that only extends a pending multi-byte prefix gives no result
// - latency: the first result of an item is valid the cycle after acceptance
// - throughput: valid text flows at one byte per cycle while the receiver does
//   not stall; an item with m results (up to four on an error or a flush at end
//   of string) holds the input not ready while the single output register
//   drains the result list one entry per cycle, unless the receiver stalls
// - the next item is accepted in the same cycle that the last result of the
//   previous one leaves the output register
// - receiver stall: the output register holds its result and the input
//   stays not ready until the register can be loaded again
// - reset (i_rst_n low, synchronous) drops any held prefix and any pending
//   result; no clearing pass is needed

module utf8_to_utf32_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u8dec_in_if.sink           i_in,
    u8dec_out_if.source        o_out
);
    import u8dec_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // controller: accepts items and sequences the result list
    u8dec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath: held prefix, decode, pending results and output register
    u8dec_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_in       (i_in.byte_in),
        .i_end_of_string (i_in.end_of_string),
        .i_cmd           (cmd),
        .i_out_ready     (o_out.ready),
        .o_status        (status),
        .o_out_valid     (o_out.valid),
        .o_code_point    (o_out.code_point),
        .o_is_escape     (o_out.is_escape),
        .o_run_last      (o_out.run_last),
        .o_string_last   (o_out.string_last)
    );

    assign i_in.ready = in_ready;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for utf8_to_utf32_decoder_core
// depends on u8dec_pkg, u8dec_if and the decoder core rtl
`timescale 1ns / 1ps

module tb;
    import u8dec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // one expected decoder output item
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            esc;
        logic            run_last;
        logic            string_last;
    } t_cp_res;

    logic i_clk;
    logic i_rst_n;

    u8dec_in_if  in_if ();
    u8dec_out_if out_if ();

    utf8_to_utf32_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // decoder state as the testbench sees it
    logic [BYTE_W-1:0] held_seq [3];
    int unsigned       held_cnt;

    t_cp_res           step_cps [$];      // results of the byte being decoded
    t_cp_res           expected_cps [$];  // results still owed by the block
    logic [BYTE_W-1:0] text_bytes [$];    // one string waiting to be sent

    int unsigned mismatches;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // decode model
    // ------------------------------------------------------------------

    function automatic logic [LEN_W-1:0] lead_len(logic [BYTE_W-1:0] b);
        if (b < 8'h80) return LEN_1;
        if (b >= 8'hC2 && b <= 8'hDF) return LEN_2;
        if (b >= 8'hE0 && b <= 8'hEF) return LEN_3;
        if (b >= 8'hF0 && b <= 8'hF4) return LEN_4;
        return LEN_BAD;
    endfunction

    // second-byte range rules for the overlong, surrogate and too-large leads
    function automatic logic bad_second(logic [BYTE_W-1:0] lead, logic [BYTE_W-1:0] c);
        return (lead == LEAD_E0 && c < MIN_AFT_E0) || (lead == LEAD_ED && c > MAX_AFT_ED) ||
               (lead == LEAD_F0 && c < MIN_AFT_F0) || (lead == LEAD_F4 && c > MAX_AFT_F4);
    endfunction

    function automatic void emit_cp(logic [CP_W-1:0] cp, logic esc);
        step_cps.push_back('{cp: cp, esc: esc, run_last: 1'b0, string_last: 1'b0});
    endfunction

    // every held byte comes out as an escape, lead first
    function automatic void flush_held();
        for (int unsigned i = 0; i < held_cnt; i++)
            emit_cp(ESC_BASE | {13'd0, held_seq[i]}, 1'b1);
        held_cnt = 0;
    endfunction

    function automatic void start_fresh(logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        n = lead_len(b);
        if (n == LEN_1) begin
            emit_cp({13'd0, b}, 1'b0);
        end else if (n == LEN_BAD) begin
            emit_cp(ESC_BASE | {13'd0, b}, 1'b1);
        end else begin
            held_seq[0] = b;
            held_cnt    = 1;
        end
    endfunction

    function automatic logic [CP_W-1:0] join_seq(logic [LEN_W-1:0] n, logic [BYTE_W-1:0] b);
        if (n == LEN_2)
            return {10'd0, held_seq[0][4:0], b[5:0]};
        if (n == LEN_3)
            return {5'd0, held_seq[0][3:0], held_seq[1][5:0], b[5:0]};
        return {held_seq[0][2:0], held_seq[1][5:0], held_seq[2][5:0], b[5:0]};
    endfunction

    // works out the results of one accepted byte and queues them
    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic eos);
        logic [LEN_W-1:0] n;
        int unsigned      pos;
        logic             ok;
        step_cps.delete();
        if (held_cnt > 0) begin
            n   = lead_len(held_seq[0]);
            pos = held_cnt;
            ok  = (n >= LEN_2) && (pos < n) && ((b & TRAIL_MASK) == TRAIL_TAG) &&
                  !(pos == 1 && bad_second(held_seq[0], b));
            if (ok && pos + 1 == n) begin
                emit_cp(join_seq(n, b), 1'b0);
                held_cnt = 0;
            end else if (ok && pos < 3) begin
                held_seq[pos] = b;
                held_cnt      = pos + 1;
            end else begin
                // early error: escape the prefix, then the breaking byte starts over
                flush_held();
                start_fresh(b);
            end
        end else begin
            start_fresh(b);
        end
        if (eos)
            flush_held();
        if (step_cps.size() > 0) begin
            step_cps[step_cps.size()-1].run_last    = 1'b1;
            step_cps[step_cps.size()-1].string_last = eos;
        end
        foreach (step_cps[i])
            expected_cps.push_back(step_cps[i]);
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------

    // one input item; inputs move on the falling edge, acceptance is seen on the rising
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.byte_in       <= b;
        in_if.end_of_string <= eos;
        do @(posedge i_clk); while (!in_if.ready);
        decode_byte(b, eos);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    // receiver back-pressure
    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_out
        t_cp_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_cps.size() == 0) begin
                $error("unexpected item: code_point %h", out_if.code_point);
                mismatches++;
            end else begin
                want = expected_cps.pop_front();
                if (out_if.code_point !== want.cp) begin
                    $error("code_point: expected %h, got %h", want.cp, out_if.code_point);
                    mismatches++;
                end
                if (out_if.is_escape !== want.esc) begin
                    $error("is_escape: expected %b, got %b", want.esc, out_if.is_escape);
                    mismatches++;
                end
                if (out_if.run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, out_if.run_last);
                    mismatches++;
                end
                if (out_if.string_last !== want.string_last) begin
                    $error("string_last: expected %b, got %b", want.string_last,
                           out_if.string_last);
                    mismatches++;
                end
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic append_utf8(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            text_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    // scalar value of an evenly chosen encoded length, surrogates left out
    function automatic logic [CP_W-1:0] random_scalar();
        case ($urandom_range(3))
            0: return CP_W'($urandom_range(21'h7F));
            1: return CP_W'($urandom_range(21'h7FF, 21'h80));
            2: begin
                if ($urandom_range(1))
                    return CP_W'($urandom_range(21'hD7FF, 21'h800));
                return CP_W'($urandom_range(21'hFFFF, 21'hE000));
            end
            default: return CP_W'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
    endfunction

    // ascii bounds, with a string end on plain text
    task automatic test_ascii_bounds();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // smallest two- and three-byte forms and the top scalar
    task automatic test_valid_sequences();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(LEAD_E0, 1'b0);
        send_byte(MIN_AFT_E0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(LEAD_F4, 1'b0);
        send_byte(MAX_AFT_F4, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // bytes that can never start a sequence
    task automatic test_bad_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // surrogate and overlong second bytes
    task automatic test_bad_second();
        send_byte(LEAD_ED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(LEAD_F0, 1'b0);
        send_byte(8'h8F, 1'b0);
    endtask

    // prefix broken after two bytes, the breaking ascii byte is decoded again
    task automatic test_early_error();
        send_byte(8'hE1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // three escapes from the broken prefix plus a held lead flushed at string end
    task automatic test_flush_at_end();
        send_byte(8'hF1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC2, 1'b1);
    endtask

    // strings of mostly well-formed text, with truncated, broken and noise pieces
    task automatic test_random_text(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned kind;
        int unsigned mark;
        int unsigned span;
        sent = 0;
        while (sent < n_bytes) begin
            text_bytes.delete();
            repeat ($urandom_range(6, 1)) begin
                kind = $urandom_range(99);
                mark = text_bytes.size();
                if (kind < 65) begin
                    append_utf8(random_scalar());
                end else if (kind < 75) begin
                    // truncated sequence
                    append_utf8(random_scalar());
                    span = text_bytes.size() - mark;
                    if (span > 1)
                        repeat ($urandom_range(span - 1, 1)) void'(text_bytes.pop_back());
                end else if (kind < 85) begin
                    // one byte after the lead replaced by anything
                    append_utf8(random_scalar());
                    span = text_bytes.size() - mark;
                    if (span > 1)
                        text_bytes[mark + $urandom_range(span - 1, 1)] =
                            BYTE_W'($urandom_range(255));
                end else if (kind < 92) begin
                    // range-checked lead with any trail bytes behind it
                    case ($urandom_range(3))
                        0: text_bytes.push_back(LEAD_E0);
                        1: text_bytes.push_back(LEAD_ED);
                        2: text_bytes.push_back(LEAD_F0);
                        default: text_bytes.push_back(LEAD_F4);
                    endcase
                    repeat ($urandom_range(3, 1))
                        text_bytes.push_back(BYTE_W'($urandom_range(8'hBF, 8'h80)));
                end else begin
                    text_bytes.push_back(BYTE_W'($urandom_range(255)));
                end
            end
            send_text();
            sent += text_bytes.size();
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.byte_in       = '0;
        in_if.end_of_string = 1'b0;
        out_if.ready        = 1'b0;
        held_cnt            = 0;
        mismatches          = 0;
        cycles              = 0;
        send_idle_pct       = 17;
        recv_stall_pct      = 60;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles now and then, receiver stalls often
        test_ascii_bounds();
        test_valid_sequences();
        test_bad_leads();
        test_bad_second();
        test_early_error();
        test_flush_at_end();
        test_random_text(130);

        // swap the pressure
        send_idle_pct  = 60;
        recv_stall_pct = 17;
        test_random_text(130);

        // full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_text(140);

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        while (expected_cps.size() != 0) @(posedge i_clk);
        // catch any stray item after the last expected one
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_cps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
